FILE: rtl/core/bgts_pkg.sv
package bgts_pkg;

    localparam int FrameW     = 64;
    localparam int BarW       = 32;
    localparam int RateW      = 20;
    localparam int CibW       = 8;
    localparam int CntW       = BarW + CibW;
    localparam int InDataW    = 200;
    localparam int OutDataW   = 192;
    localparam int CfgAddrW   = 6;
    localparam int CfgDataW   = 64;
    localparam int DivStepDef = 4;

    // floor(x / 5) = (x * LeadMul) >> LeadShift for any x below 2**22
    localparam int LeadShift  = 22;
    localparam logic [RateW-1:0] LeadMul = RateW'(838861);

    localparam logic OpSchedule = 1'b0;
    localparam logic OpAlign    = 1'b1;

    typedef enum logic [2:0] {
        REG_BAR_FRAMES    = 3'd0,
        REG_RENDER_OFFSET = 3'd1,
        REG_SAMPLE_RATE   = 3'd2,
        REG_EPOCH_VALID   = 3'd3,
        REG_EPOCH_FRAME   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [BarW-1:0]   bar_frames;
        logic [FrameW-1:0] render_offset;
        logic [RateW-1:0]  sample_rate;
        logic              epoch_valid;
        logic [FrameW-1:0] epoch_frame;
    } cfg_t;

    // per-item side info that rides along with the divider
    typedef struct packed {
        logic              op;
        logic              ok;
        logic              ge;
        logic [FrameW-1:0] cur;
        logic [FrameW-1:0] cif;
        logic [CntW-1:0]   cnt;
        logic [FrameW-1:0] minraw;
        logic [FrameW-1:0] x;
    } ctl_t;

    // musical -> raw, msb flags overflow
    function automatic logic [FrameW:0] to_raw(logic [FrameW-1:0] v, logic [FrameW-1:0] off);
        logic              neg;
        logic [FrameW-1:0] mag;
        logic [FrameW:0]   r;
        neg = off[FrameW-1];
        mag = neg ? (~off + FrameW'(1)) : off;
        if (neg) begin
            r = {1'b0, v} + {1'b0, mag};
        end else begin
            r = {1'b0, (v > mag) ? (v - mag) : '0};
        end
        return r;
    endfunction

    // raw -> musical, msb flags overflow
    function automatic logic [FrameW:0] to_musical(logic [FrameW-1:0] v, logic [FrameW-1:0] off);
        logic              neg;
        logic [FrameW-1:0] mag;
        logic [FrameW:0]   r;
        neg = off[FrameW-1];
        mag = neg ? (~off + FrameW'(1)) : off;
        if (neg) begin
            r = {1'b0, (v > mag) ? (v - mag) : '0};
        end else begin
            r = {1'b0, v} + {1'b0, mag};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bgts_cfg.sv
module bgts_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgts_pkg::CfgAddrW-1:0]     paddr,
    input  logic [bgts_pkg::CfgDataW-1:0]     pwdata,
    output logic [bgts_pkg::CfgDataW-1:0]     prdata,
    output bgts_pkg::cfg_t                    cfg,
    output logic [bgts_pkg::RateW-1:0]        lead
);

    bgts_pkg::cfg_t                        cfg_reg;
    logic [bgts_pkg::RateW-1:0]            lead_reg;
    logic [2*bgts_pkg::RateW-1:0]          lead_prod;
    logic                                  wr_en;
    bgts_pkg::reg_idx_t                    idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = bgts_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bar_frames    <= bgts_pkg::BarW'(96000);
            cfg_reg.render_offset <= '0;
            cfg_reg.sample_rate   <= bgts_pkg::RateW'(48000);
            cfg_reg.epoch_valid   <= 1'b0;
            cfg_reg.epoch_frame   <= '0;
        end else if (wr_en) begin
            case (idx)
                bgts_pkg::REG_BAR_FRAMES:    cfg_reg.bar_frames <= pwdata[bgts_pkg::BarW-1:0];
                bgts_pkg::REG_RENDER_OFFSET: cfg_reg.render_offset <= pwdata;
                bgts_pkg::REG_SAMPLE_RATE:   cfg_reg.sample_rate <= pwdata[bgts_pkg::RateW-1:0];
                bgts_pkg::REG_EPOCH_VALID:   cfg_reg.epoch_valid <= pwdata[0];
                bgts_pkg::REG_EPOCH_FRAME:   cfg_reg.epoch_frame <= pwdata;
                default: ;
            endcase
        end
    end

    // minimum lead = sample_rate / 5
    assign lead_prod = cfg_reg.sample_rate * bgts_pkg::LeadMul;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= bgts_pkg::RateW'(9600);
        end else begin
            lead_reg <= bgts_pkg::RateW'(lead_prod >> bgts_pkg::LeadShift);
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            bgts_pkg::REG_BAR_FRAMES:    prdata = {32'b0, cfg_reg.bar_frames};
            bgts_pkg::REG_RENDER_OFFSET: prdata = cfg_reg.render_offset;
            bgts_pkg::REG_SAMPLE_RATE:   prdata = {44'b0, cfg_reg.sample_rate};
            bgts_pkg::REG_EPOCH_VALID:   prdata = {63'b0, cfg_reg.epoch_valid};
            bgts_pkg::REG_EPOCH_FRAME:   prdata = cfg_reg.epoch_frame;
            default:                     prdata = '0;
        endcase
    end

    assign cfg  = cfg_reg;
    assign lead = lead_reg;

endmodule

FILE: rtl/core/bgts_front.sv
module bgts_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  bgts_pkg::cfg_t                 cfg,
    input  logic [bgts_pkg::RateW-1:0]     lead,
    input  logic                           in_valid,
    input  logic [bgts_pkg::InDataW-1:0]   in_data,
    input  logic                           in_op,
    output logic                           out_valid,
    output logic [bgts_pkg::FrameW-1:0]    out_elapsed,
    output bgts_pkg::ctl_t                 out_ctl
);

    logic                           v1_reg;
    logic                           op1_reg;
    logic [bgts_pkg::FrameW-1:0]    cur1_reg;
    logic [bgts_pkg::CibW-1:0]      cib1_reg;
    logic [bgts_pkg::FrameW-1:0]    est1_reg;
    logic [bgts_pkg::FrameW-1:0]    cif1_reg;

    logic                           v2_reg;
    logic [bgts_pkg::FrameW-1:0]    elapsed_reg;
    bgts_pkg::ctl_t                 ctl_reg;

    logic [bgts_pkg::FrameW-1:0]    sel_frame;
    logic [bgts_pkg::FrameW:0]      mus;
    logic [bgts_pkg::FrameW-1:0]    epoch_eff;
    logic                           ge;
    logic [bgts_pkg::FrameW:0]      minraw;
    bgts_pkg::ctl_t                 ctl_next;
    logic [bgts_pkg::FrameW-1:0]    elapsed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg     <= in_op;
            cur1_reg    <= in_data[63:0];
            cib1_reg    <= in_data[71:64];
            est1_reg    <= in_data[135:72];
            cif1_reg    <= in_data[199:136];
            elapsed_reg <= elapsed_next;
            ctl_reg     <= ctl_next;
        end
    end

    always_comb begin
        sel_frame = (op1_reg == bgts_pkg::OpAlign) ? est1_reg : cur1_reg;
        mus       = bgts_pkg::to_musical(sel_frame, cfg.render_offset);
        if (op1_reg == bgts_pkg::OpAlign || cfg.epoch_valid) begin
            epoch_eff = cfg.epoch_frame;
        end else begin
            epoch_eff = '0;
        end
        ge           = mus[63:0] >= epoch_eff;
        elapsed_next = ge ? (mus[63:0] - epoch_eff) : '0;
        minraw       = {1'b0, cur1_reg} + {45'b0, lead};

        ctl_next.op     = op1_reg;
        ctl_next.ge     = ge;
        ctl_next.cur    = cur1_reg;
        ctl_next.cif    = cif1_reg;
        ctl_next.cnt    = cib1_reg * cfg.bar_frames;
        ctl_next.minraw = minraw[63:0];
        ctl_next.x      = mus[63:0];
        if (op1_reg == bgts_pkg::OpAlign) begin
            ctl_next.ok = (cfg.bar_frames != '0) && !mus[64] && cfg.epoch_valid && ge;
        end else begin
            ctl_next.ok = (cfg.bar_frames != '0) && !mus[64] && !minraw[64];
        end
    end

    assign out_valid   = v2_reg;
    assign out_elapsed = elapsed_reg;
    assign out_ctl     = ctl_reg;

endmodule

FILE: rtl/core/bgts_div.sv
module bgts_div #(
    parameter int STEP = bgts_pkg::DivStepDef
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic [bgts_pkg::BarW-1:0]      divisor,
    input  logic                           in_valid,
    input  logic [bgts_pkg::FrameW-1:0]    in_dividend,
    input  bgts_pkg::ctl_t                 in_ctl,
    output logic                           out_valid,
    output logic [bgts_pkg::BarW-1:0]      out_rem,
    output bgts_pkg::ctl_t                 out_ctl
);

    localparam int NStg = bgts_pkg::FrameW / STEP;

    logic                           v_reg   [NStg];
    logic [bgts_pkg::FrameW-1:0]    dvd_reg [NStg];
    logic [bgts_pkg::BarW-1:0]      rem_reg [NStg];
    bgts_pkg::ctl_t                 ctl_reg [NStg];

    logic [bgts_pkg::FrameW-1:0]    dvd_next [NStg];
    logic [bgts_pkg::BarW-1:0]      rem_next [NStg];

    // restoring division, STEP dividend bits per stage, only the remainder is kept
    for (genvar g = 0; g < NStg; g++) begin : g_stg
        always_comb begin
            logic [bgts_pkg::FrameW-1:0] d;
            logic [bgts_pkg::BarW:0]     r;
            d = (g == 0) ? in_dividend : dvd_reg[(g == 0) ? 0 : g-1];
            r = {1'b0, (g == 0) ? '0 : rem_reg[(g == 0) ? 0 : g-1]};
            for (int k = 0; k < STEP; k++) begin
                r = {r[bgts_pkg::BarW-1:0], d[bgts_pkg::FrameW-1]};
                d = {d[bgts_pkg::FrameW-2:0], 1'b0};
                if (r >= {1'b0, divisor}) begin
                    r = r - {1'b0, divisor};
                end
            end
            dvd_next[g] = d;
            rem_next[g] = r[bgts_pkg::BarW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (adv) begin
                v_reg[g] <= (g == 0) ? in_valid : v_reg[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dvd_reg[g] <= dvd_next[g];
                rem_reg[g] <= rem_next[g];
                ctl_reg[g] <= (g == 0) ? in_ctl : ctl_reg[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign out_valid = v_reg[NStg-1];
    assign out_rem   = rem_reg[NStg-1];
    assign out_ctl   = ctl_reg[NStg-1];

endmodule

FILE: rtl/core/bgts_back.sv
module bgts_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  bgts_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    input  logic [bgts_pkg::BarW-1:0]      in_rem,
    input  bgts_pkg::ctl_t                 in_ctl,
    output logic                           out_valid,
    output logic                           out_ok,
    output logic [bgts_pkg::FrameW-1:0]    out_cd,
    output logic [bgts_pkg::FrameW-1:0]    out_tr,
    output logic [bgts_pkg::FrameW-1:0]    out_tm
);

    localparam int W = bgts_pkg::FrameW;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    bgts_pkg::ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [W-1:0] val1_reg, val2_reg, cd2_reg, next3_reg, cd4_reg, tm4_reg;
    logic [W-1:0] cd5_reg, tm5_reg, tr5_reg;
    logic [W:0]   inc2_reg;
    logic         ok6_reg;
    logic [W-1:0] cd6_reg, tr6_reg, tm6_reg;

    logic [W-1:0] bf64;
    logic [W-1:0] base1;
    logic [W-1:0] add1;
    logic [W:0]   sum1;
    logic [W:0]   raw2;
    logic         sel3;
    logic [W:0]   raw4;
    logic [W:0]   tms4;
    logic [W:0]   raw5;
    logic [W-1:0] cd6;
    logic         ok6;
    bgts_pkg::ctl_t c1_next, c2_next, c3_next, c4_next, c5_next;

    assign bf64 = {32'b0, cfg.bar_frames};

    // stage 1: bar boundary (schedule) or floor boundary plus rounding (align)
    always_comb begin
        c1_next = in_ctl;
        if (in_ctl.op == bgts_pkg::OpAlign || in_ctl.ge) begin
            base1 = in_ctl.x - {32'b0, in_rem};
        end else begin
            base1 = cfg.epoch_valid ? cfg.epoch_frame : '0;
        end
        if (in_ctl.op == bgts_pkg::OpSchedule) begin
            add1 = bf64;
        end else begin
            add1 = (in_rem > (cfg.bar_frames >> 1)) ? bf64 : '0;
        end
        sum1       = {1'b0, base1} + {1'b0, add1};
        c1_next.ok = in_ctl.ok && !sum1[W];
    end

    // stage 2: first countdown guess and the one-bar-later alternative
    always_comb begin
        c2_next = c1_reg;
        raw2    = bgts_pkg::to_raw(val1_reg, cfg.render_offset);
        if (c1_reg.op == bgts_pkg::OpSchedule) begin
            c2_next.ok = c1_reg.ok && !raw2[W];
        end
    end

    // stage 3: push out a bar when the lead is too short
    always_comb begin
        c3_next    = c2_reg;
        sel3       = (c2_reg.op == bgts_pkg::OpSchedule) && (cd2_reg <= c2_reg.minraw);
        c3_next.ok = c2_reg.ok && !(sel3 && inc2_reg[W]);
    end

    // stage 4: countdown raw frame and count-in bars
    always_comb begin
        c4_next = c3_reg;
        raw4    = bgts_pkg::to_raw(next3_reg, cfg.render_offset);
        if (c3_reg.op == bgts_pkg::OpSchedule) begin
            tms4       = {1'b0, next3_reg} + {25'b0, c3_reg.cnt};
            c4_next.ok = c3_reg.ok && !tms4[W] && !raw4[W];
        end else begin
            tms4       = {1'b0, next3_reg};
            c4_next.ok = c3_reg.ok;
        end
    end

    // stage 5: target raw frame
    always_comb begin
        c5_next    = c4_reg;
        raw5       = bgts_pkg::to_raw(tm4_reg, cfg.render_offset);
        c5_next.ok = c4_reg.ok && !raw5[W];
    end

    // stage 6: count-in back off (align) and ordering checks
    always_comb begin
        if (c5_reg.op == bgts_pkg::OpAlign) begin
            cd6 = tr5_reg - c5_reg.cif;
            ok6 = c5_reg.ok && (tr5_reg >= c5_reg.cif);
        end else begin
            cd6 = cd5_reg;
            ok6 = c5_reg.ok;
        end
        ok6 = ok6 && (cd6 > c5_reg.cur) && (tr5_reg >= cd6);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg    <= c1_next;
            val1_reg  <= sum1[W-1:0];
            c2_reg    <= c2_next;
            val2_reg  <= val1_reg;
            cd2_reg   <= raw2[W-1:0];
            inc2_reg  <= {1'b0, val1_reg} + {1'b0, bf64};
            c3_reg    <= c3_next;
            next3_reg <= sel3 ? inc2_reg[W-1:0] : val2_reg;
            c4_reg    <= c4_next;
            cd4_reg   <= raw4[W-1:0];
            tm4_reg   <= tms4[W-1:0];
            c5_reg    <= c5_next;
            cd5_reg   <= cd4_reg;
            tm5_reg   <= tm4_reg;
            tr5_reg   <= raw5[W-1:0];
            ok6_reg   <= ok6;
            cd6_reg   <= ok6 ? cd6 : '0;
            tr6_reg   <= ok6 ? tr5_reg : '0;
            tm6_reg   <= ok6 ? tm5_reg : '0;
        end
    end

    assign out_valid = v6_reg;
    assign out_ok    = ok6_reg;
    assign out_cd    = cd6_reg;
    assign out_tr    = tr6_reg;
    assign out_tm    = tm6_reg;

endmodule

FILE: rtl/core/bar_grid_transport_scheduler_unit.sv
// bar-grid transport scheduler
// input stream s_*: one scheduling request per word, s_tuser[0] is the op
// (0 = schedule on the next bar after now, 1 = snap an estimate to the bar grid)
// result stream m_*: exactly one result word per request, in request order;
// m_tuser[0] is set when a schedule was found, else all frame fields are zero
// apb port: bar_frames, render_offset, sample_rate, epoch_valid, epoch_frame at
// byte addresses 0, 8, 16, 24, 32; write only while no request is in flight
// latency: 8 + 64/DIV_STEP cycles from accept to result (24 with DIV_STEP = 4),
// set by the remainder divider, DIV_STEP dividend bits per stage
// throughput: one request per cycle, all stages move together
// a stall on m_tready freezes the whole pipeline and drops s_tready the same cycle
// reset clears every valid bit and loads the register defaults; no result appears
// until a request is accepted
module bar_grid_transport_scheduler_unit #(
    parameter int DIV_STEP = bgts_pkg::DivStepDef
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // current_frame, count_in_bars, estimated_frame, count_in_frames
    input  logic [bgts_pkg::InDataW-1:0]      s_tdata,
    // op
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // countdown_frame, target_raw_frame, target_musical_frame
    output logic [bgts_pkg::OutDataW-1:0]     m_tdata,
    // valid_res
    output logic [0:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgts_pkg::CfgAddrW-1:0]     paddr,
    input  logic [bgts_pkg::CfgDataW-1:0]     pwdata,
    output logic [bgts_pkg::CfgDataW-1:0]     prdata,
    output logic                              pready
);

    bgts_pkg::cfg_t                   cfg;
    logic [bgts_pkg::RateW-1:0]       lead;
    logic                             adv;
    logic                             f_valid;
    logic [bgts_pkg::FrameW-1:0]      f_elapsed;
    bgts_pkg::ctl_t                   f_ctl;
    logic                             d_valid;
    logic [bgts_pkg::BarW-1:0]        d_rem;
    bgts_pkg::ctl_t                   d_ctl;
    logic                             b_ok;
    logic [bgts_pkg::FrameW-1:0]      b_cd;
    logic [bgts_pkg::FrameW-1:0]      b_tr;
    logic [bgts_pkg::FrameW-1:0]      b_tm;

    assign pready   = 1'b1;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    bgts_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .lead    (lead)
    );

    bgts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .cfg         (cfg),
        .lead        (lead),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .in_op       (s_tuser[0]),
        .out_valid   (f_valid),
        .out_elapsed (f_elapsed),
        .out_ctl     (f_ctl)
    );

    bgts_div #(
        .STEP (DIV_STEP)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .divisor     (cfg.bar_frames),
        .in_valid    (f_valid),
        .in_dividend (f_elapsed),
        .in_ctl      (f_ctl),
        .out_valid   (d_valid),
        .out_rem     (d_rem),
        .out_ctl     (d_ctl)
    );

    bgts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (d_valid),
        .in_rem    (d_rem),
        .in_ctl    (d_ctl),
        .out_valid (m_tvalid),
        .out_ok    (b_ok),
        .out_cd    (b_cd),
        .out_tr    (b_tr),
        .out_tm    (b_tm)
    );

    assign m_tdata    = {b_tm, b_tr, b_cd};
    assign m_tuser[0] = b_ok;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result carries nonzero frames");

    a_valid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[127:64] >= m_tdata[63:0]) && (m_tdata[63:0] != '0))
        else $error("valid result breaks countdown ordering");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

endmodule
